// ===== rtl/core/sfrc_pkg.sv =====
// Shared constants and types for the serial frame receive checker.
package sfrc_pkg;

    // Frame store capacity in bytes
    localparam int unsigned MAX_FRAME = 13;
    localparam int unsigned CNT_W     = $clog2(MAX_FRAME + 1);

    // Frame layout constants
    localparam logic [7:0] END_BYTE   = 8'h0F;
    localparam logic [7:0] START_BYTE = 8'hF0;
    localparam logic [7:0] TYPE_BYTE  = 8'h05;
    localparam logic [7:0] PAD_BYTE   = 8'hFF;
    localparam logic [7:0] MARK_A     = 8'h40;
    localparam logic [7:0] MARK_B     = 8'h41;
    localparam logic [7:0] TAG_A      = 8'h01;
    localparam logic [7:0] TAG_B      = 8'h02;
    localparam logic [7:0] LEN_OFFSET = 8'd7;
    localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(13);

    // Only the leading header/payload bytes are ever read back
    localparam int unsigned HDR_BYTES = 10;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);

    // One frame check result
    typedef struct packed {
        logic       frame_valid;
        logic [3:0] frame_length;
        logic [7:0] payload_first;
        logic [7:0] payload_second;
        logic [7:0] payload_third;
    } t_result;

endpackage

// ===== rtl/core/sfrc_in_reg.sv =====
// Input register stage for received bytes.
module sfrc_in_reg
    import sfrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_data
);

    logic       r_valid;
    logic [7:0] r_data;

    // Take a new item whenever the stage is empty or drains this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload holds no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/sfrc_frame_check.sv =====
// Frame accumulation state and end-of-frame checks.
module sfrc_frame_check
    import sfrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_data,
    output logic       o_is_end,
    output t_result    o_result
);

    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_parity;
    logic [7:0]       r_hdr [HDR_BYTES];
    logic [7:0]       r_prev1;
    logic [7:0]       r_prev2;

    logic             store;
    logic [CNT_W-1:0] len;
    logic [7:0]       parity_after;
    logic [7:0]       len8;
    logic             hdr_ok;

    // Byte at a header position, with bypass of the byte stored this cycle
    function automatic logic [7:0] hdr_byte(input int unsigned pos,
                                            input logic st,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic [7:0] b,
                                            input logic [7:0] held);
        logic [7:0] v;
        v = held;
        if (st && (cnt == CNT_W'(pos))) begin
            v = b;
        end
        return v;
    endfunction

    // Store or drop, then length and parity including this byte
    always_comb begin
        store        = (r_count < CNT_W'(MAX_FRAME));
        len          = store ? (r_count + CNT_W'(1)) : '0;
        parity_after = store ? (r_parity ^ i_data) : 8'h00;
        len8         = 8'(len);
        o_is_end     = (i_data == END_BYTE);
    end

    // Header, marker, pad and checksum checks; len >= 13 keeps all reads in frame
    always_comb begin
        hdr_ok = store
              && (len >= MIN_LEN)
              && (r_hdr[0] == START_BYTE)
              && (r_hdr[1] == TYPE_BYTE)
              && (r_hdr[2] == (len8 - LEN_OFFSET))
              && (r_hdr[3] == MARK_A)
              && (r_hdr[4] == TAG_A)
              && (r_hdr[6] == MARK_B)
              && (r_hdr[7] == TAG_B)
              && (r_prev2 == PAD_BYTE)
              && (parity_after == END_BYTE);
    end

    // Result fields; positions at or beyond the length read as zero
    always_comb begin
        o_result.frame_valid    = hdr_ok;
        o_result.frame_length   = len[3:0];
        o_result.payload_first  = (len > CNT_W'(5))
            ? hdr_byte(5, store, r_count, i_data, r_hdr[5]) : 8'h00;
        o_result.payload_second = (len > CNT_W'(8))
            ? hdr_byte(8, store, r_count, i_data, r_hdr[8]) : 8'h00;
        o_result.payload_third  = (len > CNT_W'(9))
            ? hdr_byte(9, store, r_count, i_data, r_hdr[9]) : 8'h00;
    end

    // Count and running parity; a terminator restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_parity <= 8'h00;
        end else if (i_advance) begin
            if (o_is_end) begin
                r_count  <= '0;
                r_parity <= 8'h00;
            end else begin
                r_count  <= len;
                r_parity <= parity_after;
            end
        end
    end

    // Held header bytes and the two most recent stored bytes
    always_ff @(posedge i_clk) begin
        if (i_advance && store) begin
            for (int k = 0; k < HDR_BYTES; k++) begin
                if (r_count == CNT_W'(k)) begin
                    r_hdr[k] <= i_data;
                end
            end
            r_prev1 <= i_data;
            r_prev2 <= r_prev1;
        end
    end

endmodule

// ===== rtl/core/serial_frame_receive_check_core.sv =====
// Top level of the serial frame receive checker with its result register.
//
// Usage: received bytes enter on i_valid/o_ready with i_rx_data, one item
// per accepting clock edge. Each byte is stored into the current frame while
// fewer than 13 bytes are held; a byte arriving at a full store is dropped
// and the frame restarts. Every 0x0F byte closes the frame and yields one
// result item on o_valid/i_ready: validity flag, length and payload bytes
// 5, 8 and 9. Other bytes produce no result.
// Path: an accepted byte is held in the input register, where it is checked;
// a terminator's result is then loaded into the result register.
// Throughput: one byte per cycle while no terminator is held back, as the check
// is combinational between the input register and the result register.
// When the receiver stalls with a result pending, bytes that yield no result
// keep flowing; a terminator waits in the input register and o_ready drops
// until the pending result is taken.
// Reset (synchronous, active low) empties both registers and clears the byte
// count and running parity.
module serial_frame_receive_check_core
    import sfrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_frame_valid,
    output logic [3:0] o_frame_length,
    output logic [7:0] o_payload_first,
    output logic [7:0] o_payload_second,
    output logic [7:0] o_payload_third
);

    logic       in_valid;
    logic [7:0] in_data;
    logic       is_end;
    logic       advance;
    t_result    result;

    logic       r_out_valid;
    t_result    r_out;

    // Item moves on unless it yields a result and the output is blocked
    assign advance = in_valid && (!is_end || !r_out_valid || i_ready);

    sfrc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_rx_data),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_data    (in_data)
    );

    sfrc_frame_check u_frame_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_data    (in_data),
        .o_is_end  (is_end),
        .o_result  (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_end) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_valid    = r_out.frame_valid;
    assign o_frame_length   = r_out.frame_length;
    assign o_payload_first  = r_out.payload_first;
    assign o_payload_second = r_out.payload_second;
    assign o_payload_third  = r_out.payload_third;

endmodule
